[sv/bpa_pkg.sv]
// Shared types and constants for the binary patch applier.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned SRC_DEPTH = 65536;
  localparam int unsigned TGT_DEPTH = 65536;
  localparam int unsigned SRC_AW    = $clog2(SRC_DEPTH);
  localparam int unsigned TGT_AW    = $clog2(TGT_DEPTH);
  localparam int unsigned WP_W      = TGT_AW + 1;

  localparam logic [31:0] MAGIC_WORD     = 32'h3153_5042;
  localparam logic [32:0] CHECKSUM_BYTES = 33'd12;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PATCH = 2'd1;
  localparam logic [1:0] CMD_CONT  = 2'd2;

  localparam logic [0:0] REG_PATCH_LEN = 1'b0;
  localparam logic [0:0] REG_SRC_SIZE  = 1'b1;

  localparam logic [1:0] MODE_SRC_READ = 2'd0;
  localparam logic [1:0] MODE_LITERAL  = 2'd1;
  localparam logic [1:0] MODE_SRC_COPY = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_SRC_SIZE = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_MISUSE   = 3'd4;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_SRCSIZE, PH_TGTSIZE, PH_METALEN, PH_METASKIP,
    PH_ACTION, PH_OFFSET, PH_LITERAL, PH_COPY, PH_DONE, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    SEL_ZERO, SEL_LIT, SEL_SRC, SEL_TGT
  } byte_sel_e;

  // Decode result for one word, handed from control to the result stage.
  typedef struct packed {
    logic              src_re;
    logic [SRC_AW-1:0] src_raddr;
    logic              tgt_re;
    logic [TGT_AW-1:0] tgt_raddr;
    logic              emit;
    byte_sel_e         sel;
    logic [7:0]        lit;
    logic [TGT_AW-1:0] addr;
    logic              busy;
    logic              done;
    logic [2:0]        err;
  } step_t;

endpackage

[sv/bpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bpa_ctrl.sv]
// Patch decoder: config registers, phase machine, varint decode, copy pointers.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic [bpa_pkg::SRC_AW-1:0] load_addr_i,
  output bpa_pkg::step_t       step_o
);
  import bpa_pkg::*;

  logic [31:0]     plen_q;
  logic [16:0]     ssize_q;
  phase_e          phase_q, phase_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic [5:0]      sh_q, sh_d;
  logic [1:0]      mode_q, mode_d;
  logic [31:0]     run_q, run_d;
  logic [WP_W-1:0] wp_q, wp_d;
  logic [31:0]     srel_q, srel_d;
  logic [31:0]     trel_q, trel_d;
  logic [31:0]     ttot_q, ttot_d;
  logic [2:0]      err_q, err_d;

  // varint datapath
  logic [31:0] term, acc_sum, acc_cont, wt_nx, vint, delta, cnt_inc, src_a;
  logic [5:0]  sh_nx;
  logic        lim_hit, lim_run, emit_ok, src_ok;

  always_comb begin
    term     = (sh_q < 6'd32) ? ({25'd0, data_byte_i[6:0]} << sh_q[4:0]) : 32'd0;
    acc_sum  = acc_q + term;
    sh_nx    = (sh_q < 6'd32) ? sh_q + 6'd7 : sh_q;
    wt_nx    = (sh_nx < 6'd32) ? (32'd1 << sh_nx[4:0]) : 32'd0;
    acc_cont = acc_sum + wt_nx;
    vint     = acc_sum;
    delta    = vint[0] ? (32'd0 - {1'b0, vint[31:1]}) : {1'b0, vint[31:1]};
    cnt_inc  = cnt_q + 32'd1;
    lim_hit  = ({1'b0, cnt_inc} + CHECKSUM_BYTES) >= {1'b0, plen_q};
    lim_run  = ({1'b0, cnt_q} + CHECKSUM_BYTES) >= {1'b0, plen_q};
    emit_ok  = ({{(32-WP_W){1'b0}}, wp_q} < ttot_q)
               && ({{(32-WP_W){1'b0}}, wp_q} < 32'(TGT_DEPTH));
    src_a    = (mode_q == MODE_SRC_READ) ? {{(32-WP_W){1'b0}}, wp_q} : srel_q;
    src_ok   = (src_a < {15'd0, ssize_q}) && (src_a < 32'(SRC_DEPTH));
  end

  always_comb begin
    phase_d = phase_q;  cnt_d  = cnt_q;  acc_d  = acc_q;  sh_d   = sh_q;
    mode_d  = mode_q;   run_d  = run_q;  wp_d   = wp_q;   srel_d = srel_q;
    trel_d  = trel_q;   ttot_d = ttot_q; err_d  = err_q;
    step_o           = '0;
    step_o.sel       = SEL_ZERO;
    step_o.src_raddr = src_a[SRC_AW-1:0];
    step_o.tgt_raddr = trel_q[TGT_AW-1:0];
    step_o.lit       = data_byte_i;
    step_o.addr      = wp_q[TGT_AW-1:0];

    if (cmd_i == CMD_LOAD) begin
      if (({{(32-SRC_AW){1'b0}}, load_addr_i} >= 32'(SRC_DEPTH)) && err_q == ERR_NONE) begin
        err_d = ERR_RANGE; phase_d = PH_HALT;
      end
    end else if (phase_q != PH_HALT) begin
      if (cmd_i == CMD_PATCH) begin
        if (phase_q == PH_COPY) begin
          err_d = ERR_MISUSE; phase_d = PH_HALT;
        end else begin
          cnt_d = cnt_inc;
          case (phase_q)
            PH_MAGIC: begin
              acc_d = acc_q | ({24'd0, data_byte_i} << {cnt_q[1:0], 3'd0});
              if (cnt_q[1:0] == 2'd3 || cnt_q >= 32'd4) begin
                acc_d = '0;
                if ((acc_q | ({24'd0, data_byte_i} << {cnt_q[1:0], 3'd0})) != MAGIC_WORD)
                begin
                  err_d = ERR_MAGIC; phase_d = PH_HALT;
                end else begin
                  phase_d = PH_SRCSIZE;
                end
              end
            end
            PH_SRCSIZE, PH_TGTSIZE, PH_METALEN, PH_ACTION, PH_OFFSET: begin
              if (data_byte_i[7]) begin
                acc_d = '0; sh_d = '0;
                case (phase_q)
                  PH_SRCSIZE: begin
                    if (vint != {15'd0, ssize_q}) begin
                      err_d = ERR_SRC_SIZE; phase_d = PH_HALT;
                    end else begin
                      phase_d = PH_TGTSIZE;
                    end
                  end
                  PH_TGTSIZE: begin
                    ttot_d = vint; phase_d = PH_METALEN;
                  end
                  PH_METALEN: begin
                    if (vint == 32'd0) begin
                      phase_d = lim_hit ? PH_DONE : PH_ACTION;
                    end else begin
                      run_d = vint; phase_d = PH_METASKIP;
                    end
                  end
                  PH_ACTION: begin
                    mode_d = vint[1:0];
                    run_d  = {2'd0, vint[31:2]} + 32'd1;
                    if (vint[1:0] == MODE_LITERAL) begin
                      phase_d = PH_LITERAL;
                    end else if (vint[1:0] == MODE_SRC_READ) begin
                      phase_d = PH_COPY;
                    end else begin
                      phase_d = PH_OFFSET;
                    end
                  end
                  default: begin
                    if (mode_q == MODE_SRC_COPY) srel_d = srel_q + delta;
                    else                         trel_d = trel_q + delta;
                    phase_d = PH_COPY;
                  end
                endcase
              end else begin
                acc_d = acc_cont; sh_d = sh_nx;
              end
            end
            PH_METASKIP: begin
              run_d = run_q - 32'd1;
              if (run_q == 32'd1) phase_d = lim_hit ? PH_DONE : PH_ACTION;
            end
            PH_LITERAL: begin
              if (emit_ok) begin
                step_o.emit = 1'b1;
                step_o.sel  = SEL_LIT;
                wp_d        = wp_q + 1'b1;
                run_d       = run_q - 32'd1;
                if (run_q == 32'd1) phase_d = lim_hit ? PH_DONE : PH_ACTION;
              end else begin
                err_d = ERR_RANGE; phase_d = PH_HALT;
              end
            end
            default: ;
          endcase
        end
      end else if (cmd_i == CMD_CONT && phase_q == PH_COPY) begin
        if (mode_q == MODE_SRC_READ || mode_q == MODE_SRC_COPY) begin
          step_o.src_re = src_ok;
          step_o.sel    = src_ok ? SEL_SRC : SEL_ZERO;
          if (mode_q == MODE_SRC_COPY) srel_d = srel_q + 32'd1;
        end else begin
          step_o.tgt_re = trel_q < {{(32-WP_W){1'b0}}, wp_q};
          step_o.sel    = step_o.tgt_re ? SEL_TGT : SEL_ZERO;
          trel_d        = trel_q + 32'd1;
        end
        if (emit_ok) begin
          step_o.emit = 1'b1;
          wp_d        = wp_q + 1'b1;
          run_d       = run_q - 32'd1;
          if (run_q == 32'd1) phase_d = lim_run ? PH_DONE : PH_ACTION;
        end else begin
          step_o.src_re = 1'b0;
          step_o.tgt_re = 1'b0;
          err_d = ERR_RANGE; phase_d = PH_HALT;
        end
      end else begin
        err_d = ERR_MISUSE; phase_d = PH_HALT;
      end
    end
    step_o.busy = (phase_d == PH_COPY);
    step_o.done = (phase_d == PH_DONE);
    step_o.err  = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0; ssize_q <= '0;
      phase_q <= PH_MAGIC; cnt_q <= '0; acc_q <= '0; sh_q <= '0;
      mode_q <= '0; run_q <= '0; wp_q <= '0; srel_q <= '0;
      trel_q <= '0; ttot_q <= '0; err_q <= ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PATCH_LEN) plen_q <= cfg_wdata_i;
        if (cfg_idx_i == REG_SRC_SIZE)  ssize_q <= cfg_wdata_i[16:0];
      end
      if (accept_i) begin
        phase_q <= phase_d; cnt_q <= cnt_d; acc_q <= acc_d; sh_q <= sh_d;
        mode_q <= mode_d; run_q <= run_d; wp_q <= wp_d; srel_q <= srel_d;
        trel_q <= trel_d; ttot_q <= ttot_d; err_q <= err_d;
      end
    end
  end

endmodule

[sv/binary_patch_applier_core.sv]
// Top level of the binary patch applier: decoder, source and target RAMs,
// result register. Depends on bpa_pkg, bpa_ctrl and bpa_ram.
`timescale 1ns / 1ps
// Applies a BPS-style patch. Load source bytes first (cmd 0, by address),
// then stream patch bytes (cmd 1); while busy_res is high, send continue
// words (cmd 2), one per copied target byte. Every input word gives exactly
// one result word. The block takes one word per clock while the result is
// not stalled: decode and all pointer updates finish in the accept cycle, the
// one RAM read is registered alongside the result register, and a target byte
// is written to the target RAM in the cycle after its word is accepted. A
// target copy that reads the byte still being written is forwarded from the
// result register. A result stall backs up to the input.
// Both RAMs are 64K x 8 with no clearing pass; reads beyond the source size
// or the written target region are masked to zero by the decoder.
module binary_patch_applier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        item_valid_i,
  output logic        item_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] load_addr_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_addr_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [2:0]  error_code_o
);
  import bpa_pkg::*;

  logic              accept;
  step_t             step;
  step_t             res_q;
  logic              rvld_q;
  logic              wr_pend_q;
  logic [TGT_AW-1:0] wr_addr_q;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;
  logic [7:0]        src_rdata, tgt_rdata, res_byte;
  logic              fwd_d;

  // result register frees as soon as the word is taken
  assign item_stall_o = rvld_q && res_stall_i;
  assign accept       = item_valid_i && !item_stall_o;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .load_addr_i (load_addr_i[SRC_AW-1:0]),
    .step_o      (step)
  );

  bpa_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (accept && cmd_i == CMD_LOAD),
    .waddr_i (load_addr_i[SRC_AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (accept && step.src_re),
    .raddr_i (step.src_raddr),
    .rdata_o (src_rdata)
  );

  // target write happens in the cycle after acceptance, once the byte is known
  bpa_ram #(.WIDTH(8), .DEPTH(TGT_DEPTH)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (res_byte),
    .re_i    (accept && step.tgt_re),
    .raddr_i (step.tgt_raddr),
    .rdata_o (tgt_rdata)
  );

  always_comb begin
    case (res_q.sel)
      SEL_LIT: res_byte = res_q.lit;
      SEL_SRC: res_byte = src_rdata;
      SEL_TGT: res_byte = fwd_q ? fwd_data_q : tgt_rdata;
      default: res_byte = 8'd0;
    endcase
    if (!res_q.emit) res_byte = 8'd0;
  end

  // read of the entry being written this cycle: RAM returns old data
  assign fwd_d = wr_pend_q && (step.tgt_raddr == wr_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= 1'b0;
      wr_pend_q <= 1'b0;
      res_q     <= '0;
    end else begin
      wr_pend_q <= accept && step.emit;
      if (accept) begin
        rvld_q <= 1'b1;
        res_q  <= step;
      end else if (!res_stall_i) begin
        rvld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_addr_q  <= step.addr;
      fwd_q      <= fwd_d;
      fwd_data_q <= res_byte;
    end
  end

  assign res_valid_o  = rvld_q;
  assign out_valid_o  = res_q.emit;
  assign out_byte_o   = res_byte;
  assign out_addr_o   = res_q.emit ? 16'(res_q.addr) : 16'd0;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign error_code_o = res_q.err;

endmodule
